### rtl/tgpsm_pkg.sv
package tgpsm_pkg;

  // Width of a signed touch coordinate.
  localparam int unsigned CoordWidth = 11;

  // Compare width for the per-axis palm movement check.
  localparam int unsigned SlopWidth = 10;
  localparam int unsigned CmpWidth  = (CoordWidth + 1 > SlopWidth) ? CoordWidth + 1 : SlopWidth;

  // Millisecond periods derived from second counts fit in this width.
  localparam int unsigned MsWidth = 26;
  localparam int unsigned MsPerSec = 1000;

  // Configuration port.
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgAodEnable   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdleEnable  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgIdleTimeout = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgPalmHold    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgPalmSlop    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgDoubleTap   = 3'd5;

  // Configuration reset values.
  localparam logic [15:0] IdleTimeoutReset = 16'd15;
  localparam logic [15:0] PalmHoldReset    = 16'd2500;
  localparam logic [9:0]  PalmSlopReset    = 10'd15;
  localparam logic [15:0] DoubleTapReset   = 16'd400;

  // Event codes.
  typedef enum logic [2:0] {
    OpPress      = 3'd0,
    OpHold       = 3'd1,
    OpRelease    = 3'd2,
    OpTick       = 3'd3,
    OpSleepReq   = 3'd4,
    OpDeepReq    = 3'd5,
    OpWakeReq    = 3'd6
  } op_e;

  // Reasons reported with a commanded state.
  typedef enum logic [2:0] {
    CauseNone  = 3'd0,
    CauseDtap  = 3'd1,
    CausePalm  = 3'd2,
    CauseIdle  = 3'd3,
    CauseAuto  = 3'd4,
    CauseTouch = 3'd5,
    CauseReq   = 3'd6
  } cause_e;

endpackage

### rtl/touch_gesture_power_state_machine.sv
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_stall_o    | op, now_ms, touch_x, touch_y, wake_after_sec
// out     | output    | out_valid_o / out_stall_i  | power_state, state_set, cause
// cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// Every event gives exactly one result, held first in the input register and then in
// the result register. One event can be taken in every cycle unless the input is stalled.
// Reset puts the block in display on with the inactivity timer running and all options at
// their defaults. A stall on the output holds the result register, and with it the input
// register, so the input stalls only when both stages are full.
module touch_gesture_power_state_machine
  import tgpsm_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     in_op_i,
  input  logic [31:0]                    in_now_ms_i,
  input  logic signed [CoordWidth-1:0]   in_touch_x_i,
  input  logic signed [CoordWidth-1:0]   in_touch_y_i,
  input  logic [15:0]                    in_wake_after_sec_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     out_power_state_o,
  output logic                           out_state_set_o,
  output logic [2:0]                     out_cause_o,

  input  logic                           cfg_we_i,
  input  logic [CfgIdxWidth-1:0]         cfg_idx_i,
  input  logic [CfgDataWidth-1:0]        cfg_data_i
);

  typedef enum logic [1:0] {
    ModeOn    = 2'd0,
    ModeAod   = 2'd1,
    ModeSleep = 2'd2,
    ModeDeep  = 2'd3
  } mode_e;

  // Configuration registers. The idle timeout is kept in milliseconds as well.
  logic               aod_en_q;
  logic               idle_en_q;
  logic [MsWidth-1:0] idle_ms_q;
  logic [15:0]        palm_hold_q;
  logic [9:0]         palm_slop_q;
  logic [15:0]        dtap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aod_en_q    <= 1'b0;
      idle_en_q   <= 1'b0;
      idle_ms_q   <= MsWidth'(IdleTimeoutReset) * MsWidth'(MsPerSec);
      palm_hold_q <= PalmHoldReset;
      palm_slop_q <= PalmSlopReset;
      dtap_q      <= DoubleTapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAodEnable:   aod_en_q    <= cfg_data_i[0];
        CfgIdleEnable:  idle_en_q   <= cfg_data_i[0];
        CfgIdleTimeout: idle_ms_q   <= MsWidth'(cfg_data_i) * MsWidth'(MsPerSec);
        CfgPalmHold:    palm_hold_q <= cfg_data_i;
        CfgPalmSlop:    palm_slop_q <= cfg_data_i[9:0];
        CfgDoubleTap:   dtap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register; the auto-wake period is converted to milliseconds on the way in.
  op_e                         op_q;
  logic [31:0]                 now_q;
  logic signed [CoordWidth-1:0] x_q;
  logic signed [CoordWidth-1:0] y_q;
  logic [MsWidth-1:0]          wake_ms_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= op_e'(in_op_i);
      now_q     <= in_now_ms_i;
      x_q       <= in_touch_x_i;
      y_q       <= in_touch_y_i;
      wake_ms_q <= MsWidth'(in_wake_after_sec_i) * MsWidth'(MsPerSec);
    end
  end

  // Power and gesture state.
  mode_e                        mode_q, mode_d;
  logic [31:0]                  press_time_q, press_time_d;
  logic signed [CoordWidth-1:0] press_x_q, press_x_d;
  logic signed [CoordWidth-1:0] press_y_q, press_y_d;
  logic                         finger_q, finger_d;
  logic                         tap_armed_q, tap_armed_d;
  logic [31:0]                  first_tap_q, first_tap_d;
  logic                         idle_run_q, idle_run_d;
  logic [31:0]                  idle_start_q, idle_start_d;
  logic                         wake_armed_q, wake_armed_d;
  logic [31:0]                  wake_start_q, wake_start_d;
  logic [MsWidth-1:0]           wake_period_q, wake_period_d;

  logic   set_d;
  cause_e cause_d;

  // Elapsed times and palm movement.
  logic [31:0]                  since_press;
  logic [31:0]                  since_tap;
  logic [31:0]                  since_idle;
  logic [31:0]                  since_wake;
  logic signed [CoordWidth:0]   dx;
  logic signed [CoordWidth:0]   dy;
  logic [CoordWidth:0]          adx;
  logic [CoordWidth:0]          ady;
  logic                         palm_still;
  mode_e                        sleep_mode;

  assign since_press = now_q - press_time_q;
  assign since_tap   = now_q - first_tap_q;
  assign since_idle  = now_q - idle_start_q;
  assign since_wake  = now_q - wake_start_q;
  assign dx          = (CoordWidth+1)'(x_q) - (CoordWidth+1)'(press_x_q);
  assign dy          = (CoordWidth+1)'(y_q) - (CoordWidth+1)'(press_y_q);
  assign adx         = dx[CoordWidth] ? $unsigned(-dx) : $unsigned(dx);
  assign ady         = dy[CoordWidth] ? $unsigned(-dy) : $unsigned(dy);
  assign palm_still  = (CmpWidth'(adx) <= CmpWidth'(palm_slop_q)) &&
                       (CmpWidth'(ady) <= CmpWidth'(palm_slop_q));
  assign sleep_mode  = aod_en_q ? ModeAod : ModeSleep;

  // Event decode. Commanding a state restarts the idle start time and runs the
  // inactivity timer only in display on.
  always_comb begin
    mode_d        = mode_q;
    press_time_d  = press_time_q;
    press_x_d     = press_x_q;
    press_y_d     = press_y_q;
    finger_d      = finger_q;
    tap_armed_d   = tap_armed_q;
    first_tap_d   = first_tap_q;
    idle_run_d    = idle_run_q;
    idle_start_d  = idle_start_q;
    wake_armed_d  = wake_armed_q;
    wake_start_d  = wake_start_q;
    wake_period_d = wake_period_q;
    set_d         = 1'b0;
    cause_d       = CauseNone;

    unique case (op_q)
      OpPress: begin
        press_x_d    = x_q;
        press_y_d    = y_q;
        press_time_d = now_q;
        finger_d     = 1'b1;
        if (mode_q == ModeDeep) begin
          mode_d       = ModeOn;
          idle_run_d   = 1'b1;
          idle_start_d = now_q;
          set_d        = 1'b1;
          cause_d      = CauseTouch;
        end else if (mode_q != ModeOn) begin
          if (tap_armed_q && (since_tap < 32'(dtap_q))) begin
            tap_armed_d  = 1'b0;
            mode_d       = ModeOn;
            idle_run_d   = 1'b1;
            idle_start_d = now_q;
            set_d        = 1'b1;
            cause_d      = CauseDtap;
          end else begin
            first_tap_d = now_q;
            tap_armed_d = 1'b1;
          end
        end else begin
          idle_run_d   = 1'b0;
          idle_start_d = now_q;
        end
      end
      OpHold: begin
        if (mode_q == ModeOn && finger_q && (since_press >= 32'(palm_hold_q)) && palm_still) begin
          finger_d     = 1'b0;
          mode_d       = sleep_mode;
          idle_run_d   = 1'b0;
          idle_start_d = now_q;
          set_d        = 1'b1;
          cause_d      = CausePalm;
        end
      end
      OpRelease: begin
        finger_d = 1'b0;
        if (mode_q == ModeOn) begin
          idle_run_d   = 1'b1;
          idle_start_d = now_q;
        end
      end
      OpTick: begin
        if (wake_armed_q && (since_wake >= 32'(wake_period_q))) begin
          wake_armed_d = 1'b0;
          mode_d       = ModeOn;
          idle_run_d   = 1'b1;
          idle_start_d = now_q;
          set_d        = 1'b1;
          cause_d      = CauseAuto;
        end else if (idle_en_q && idle_run_q && (since_idle >= 32'(idle_ms_q))) begin
          mode_d       = sleep_mode;
          idle_run_d   = 1'b0;
          idle_start_d = now_q;
          set_d        = 1'b1;
          cause_d      = CauseIdle;
        end
      end
      OpSleepReq: begin
        mode_d       = sleep_mode;
        idle_run_d   = 1'b0;
        idle_start_d = now_q;
        set_d        = 1'b1;
        cause_d      = CauseReq;
      end
      OpDeepReq: begin
        mode_d       = ModeDeep;
        idle_run_d   = 1'b0;
        idle_start_d = now_q;
        set_d        = 1'b1;
        cause_d      = CauseReq;
        wake_armed_d = 1'b0;
        if (wake_ms_q != '0) begin
          wake_armed_d  = 1'b1;
          wake_start_d  = now_q;
          wake_period_d = wake_ms_q;
        end
      end
      OpWakeReq: begin
        mode_d       = ModeOn;
        idle_run_d   = 1'b1;
        idle_start_d = now_q;
        set_d        = 1'b1;
        cause_d      = CauseReq;
      end
      default: ;
    endcase
  end

  // State update and result register, both on the transfer into the result stage.
  logic [1:0] power_q;
  logic       set_q;
  cause_e     cause_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeOn;
      press_time_q  <= '0;
      press_x_q     <= '0;
      press_y_q     <= '0;
      finger_q      <= 1'b0;
      tap_armed_q   <= 1'b0;
      first_tap_q   <= '0;
      idle_run_q    <= 1'b1;
      idle_start_q  <= '0;
      wake_armed_q  <= 1'b0;
      wake_start_q  <= '0;
      wake_period_q <= '0;
    end else if (advance) begin
      mode_q        <= mode_d;
      press_time_q  <= press_time_d;
      press_x_q     <= press_x_d;
      press_y_q     <= press_y_d;
      finger_q      <= finger_d;
      tap_armed_q   <= tap_armed_d;
      first_tap_q   <= first_tap_d;
      idle_run_q    <= idle_run_d;
      idle_start_q  <= idle_start_d;
      wake_armed_q  <= wake_armed_d;
      wake_start_q  <= wake_start_d;
      wake_period_q <= wake_period_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      power_q <= mode_d;
      set_q   <= set_d;
      cause_q <= cause_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_power_state_o = power_q;
  assign out_state_set_o   = set_q;
  assign out_cause_o       = cause_q;

  // A cause is reported only with a commanded state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_state_set_o |-> out_cause_o == CauseNone)
    else $error("cause reported without a commanded state");

  // Wake causes always land in display on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_cause_o == CauseDtap || out_cause_o == CauseAuto ||
                    out_cause_o == CauseTouch) |-> out_power_state_o == ModeOn)
    else $error("wake cause without display on");

  // The inactivity timer only runs while the display is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_run_q |-> mode_q == ModeOn)
    else $error("inactivity timer running outside display on");

  // The input stalls only when both stages are held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // A transfer into the result stage always shows a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result lost after transfer into result stage");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tgpsm_pkg::*;

  // Power states as reported on the result.
  localparam logic [1:0] StOn    = 2'd0;
  localparam logic [1:0] StAod   = 2'd1;
  localparam logic [1:0] StSleep = 2'd2;
  localparam logic [1:0] StDeep  = 2'd3;

  // Codes outside the defined sets.
  localparam logic [2:0]             OpUnused  = 3'd7;
  localparam logic [CfgIdxWidth-1:0] CfgUnused = 3'd7;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned WatchdogLimit = 500;
  localparam int unsigned PhaseItems    = 250;
  localparam int unsigned RandomPhases  = 7;

  typedef enum int {
    StallNone,
    StallRandom,
    StallBursts,
    StallPeriodic
  } stall_style_e;

  typedef struct packed {
    logic [1:0] state;
    logic       set;
    cause_e     cause;
  } power_result_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [31:0]           now;
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
    logic [15:0]           wake;
  } touch_event_t;

  // One line of the directed script: an event or a register write.
  typedef struct {
    bit            is_cfg;
    bit            typed;
    touch_event_t  ev;
    power_result_t res;
  } script_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [2:0]                   in_op = OpTick;
  logic [31:0]                  in_now = '0;
  logic signed [CoordWidth-1:0] in_x = '0;
  logic signed [CoordWidth-1:0] in_y = '0;
  logic [15:0]                  in_wake = '0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_state;
  logic                         out_set;
  logic [2:0]                   out_cause;

  logic                         cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]       cfg_idx = CfgAodEnable;
  logic [CfgDataWidth-1:0]      cfg_data = '0;

  // Expected result typed into the script, sent along with the event.
  logic                         script_typed = 1'b0;
  power_result_t                script_res = '0;

  touch_gesture_power_state_machine DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_op_i             (in_op),
    .in_now_ms_i         (in_now),
    .in_touch_x_i        (in_x),
    .in_touch_y_i        (in_y),
    .in_wake_after_sec_i (in_wake),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_power_state_o   (out_state),
    .out_state_set_o     (out_set),
    .out_cause_o         (out_cause),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Predicted power controller: settings and state.
  logic                         m_aod;
  logic                         m_idle_en;
  logic [15:0]                  m_timeout;
  logic [15:0]                  m_palm;
  logic [9:0]                   m_slop;
  logic [15:0]                  m_dtap;
  logic [1:0]                   m_mode;
  logic [31:0]                  m_press_time;
  logic signed [CoordWidth-1:0] m_press_x;
  logic signed [CoordWidth-1:0] m_press_y;
  logic                         m_finger;
  logic                         m_tap_armed;
  logic [31:0]                  m_first_tap;
  logic                         m_idle_run;
  logic [31:0]                  m_idle_start;
  logic                         m_wake_armed;
  logic [31:0]                  m_wake_start;
  logic [MsWidth-1:0]           m_wake_period;
  logic                         m_cmd_set;
  cause_e                       m_cmd_cause;

  power_result_t expected_states[$];
  script_row_t   script[$];
  touch_event_t  scenario_q[$];

  int unsigned   mismatches = 0;
  int unsigned   events_taken = 0;
  int unsigned   events_sent = 0;
  int unsigned   commands_seen = 0;
  int unsigned   settings_written = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   burst_left = 0;
  int unsigned   burst_max = 4;
  int unsigned   gap_max = 3;
  int unsigned   stall_run = 0;
  logic [2:0]    stall_tick = '0;
  stall_style_e  stall_style = StallNone;
  logic [31:0]   clock_ms = '0;

  function automatic void model_reset();
    m_aod         = 1'b0;
    m_idle_en     = 1'b0;
    m_timeout     = IdleTimeoutReset;
    m_palm        = PalmHoldReset;
    m_slop        = PalmSlopReset;
    m_dtap        = DoubleTapReset;
    m_mode        = StOn;
    m_press_time  = '0;
    m_press_x     = '0;
    m_press_y     = '0;
    m_finger      = 1'b0;
    m_tap_armed   = 1'b0;
    m_first_tap   = '0;
    m_idle_run    = 1'b1;
    m_idle_start  = '0;
    m_wake_armed  = 1'b0;
    m_wake_start  = '0;
    m_wake_period = '0;
  endfunction

  function automatic void model_config(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    case (idx)
      CfgAodEnable:   m_aod = d[0];
      CfgIdleEnable:  m_idle_en = d[0];
      CfgIdleTimeout: m_timeout = d[15:0];
      CfgPalmHold:    m_palm = d[15:0];
      CfgPalmSlop:    m_slop = d[9:0];
      CfgDoubleTap:   m_dtap = d[15:0];
      default: ;
    endcase
  endfunction

  // A commanded state restarts the inactivity timer, which only runs with the display on.
  function automatic void model_command(logic [1:0] st, cause_e c, logic [31:0] now);
    m_mode       = st;
    m_idle_run   = (st == StOn);
    m_idle_start = now;
    m_cmd_set    = 1'b1;
    m_cmd_cause  = c;
  endfunction

  function automatic void model_sleep(cause_e c, logic [31:0] now);
    model_command(m_aod ? StAod : StSleep, c, now);
  endfunction

  function automatic power_result_t predict_power(touch_event_t e);
    power_result_t r;
    logic [31:0]   held;
    logic [31:0]   tap_gap;
    logic [31:0]   idle_age;
    logic [31:0]   wake_age;
    int            dx;
    int            dy;
    m_cmd_set   = 1'b0;
    m_cmd_cause = CauseNone;
    held        = e.now - m_press_time;
    tap_gap     = e.now - m_first_tap;
    idle_age    = e.now - m_idle_start;
    wake_age    = e.now - m_wake_start;
    dx          = int'($signed(e.x)) - int'(m_press_x);
    dy          = int'($signed(e.y)) - int'(m_press_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    case (e.op)
      OpPress: begin
        m_press_x    = e.x;
        m_press_y    = e.y;
        m_press_time = e.now;
        m_finger     = 1'b1;
        if (m_mode == StDeep) begin
          model_command(StOn, CauseTouch, e.now);
        end else if (m_mode != StOn) begin
          if (m_tap_armed && tap_gap < 32'(m_dtap)) begin
            m_tap_armed = 1'b0;
            model_command(StOn, CauseDtap, e.now);
          end else begin
            m_first_tap = e.now;
            m_tap_armed = 1'b1;
          end
        end else begin
          m_idle_run   = 1'b0;
          m_idle_start = e.now;
        end
      end
      OpHold: begin
        if (m_mode == StOn && m_finger && held >= 32'(m_palm) &&
            dx <= int'(m_slop) && dy <= int'(m_slop)) begin
          m_finger = 1'b0;
          model_sleep(CausePalm, e.now);
        end
      end
      OpRelease: begin
        m_finger = 1'b0;
        if (m_mode == StOn) begin
          m_idle_run   = 1'b1;
          m_idle_start = e.now;
        end
      end
      OpTick: begin
        // The auto-wake has priority over the inactivity timer.
        if (m_wake_armed && wake_age >= 32'(m_wake_period)) begin
          m_wake_armed = 1'b0;
          model_command(StOn, CauseAuto, e.now);
        end else if (m_idle_en && m_idle_run && idle_age >= 32'(m_timeout) * MsPerSec) begin
          model_sleep(CauseIdle, e.now);
          m_idle_run   = 1'b0;
          m_idle_start = e.now;
        end
      end
      OpSleepReq: model_sleep(CauseReq, e.now);
      OpDeepReq: begin
        m_wake_armed = 1'b0;
        model_command(StDeep, CauseReq, e.now);
        if (e.wake != '0) begin
          m_wake_armed  = 1'b1;
          m_wake_start  = e.now;
          m_wake_period = MsWidth'(32'(e.wake) * MsPerSec);
        end
      end
      OpWakeReq: model_command(StOn, CauseReq, e.now);
      default: ;
    endcase
    r.state = m_mode;
    r.set   = m_cmd_set;
    r.cause = m_cmd_cause;
    return r;
  endfunction

  function automatic touch_event_t mk_ev(logic [2:0] op, logic [31:0] now, int x, int y,
                                         logic [15:0] wake);
    touch_event_t e;
    e.op   = op;
    e.now  = now;
    e.x    = x[CoordWidth-1:0];
    e.y    = y[CoordWidth-1:0];
    e.wake = wake;
    return e;
  endfunction

  function automatic void add_ev(logic [2:0] op, logic [31:0] now, int x, int y, logic [15:0] wake);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.typed  = 1'b0;
    row.ev     = mk_ev(op, now, x, y, wake);
    row.res    = '0;
    script.push_back(row);
  endfunction

  function automatic void add_chk(logic [2:0] op, logic [31:0] now, int x, int y, logic [15:0] wake,
                                  logic [1:0] st, logic set, cause_e c);
    script_row_t row;
    row.is_cfg    = 1'b0;
    row.typed     = 1'b1;
    row.ev        = mk_ev(op, now, x, y, wake);
    row.res.state = st;
    row.res.set   = set;
    row.res.cause = c;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    script_row_t row;
    row.is_cfg = 1'b1;
    row.typed  = 1'b0;
    row.ev     = mk_ev(idx, 32'(d), 0, 0, '0);
    row.res    = '0;
    script.push_back(row);
  endfunction

  // Offer one event and hold it until it transfers; bursts end in a random gap.
  task automatic send_event(touch_event_t e, logic typed, power_result_t res);
    in_valid     <= 1'b1;
    in_op        <= e.op;
    in_now       <= e.now;
    in_x         <= e.x;
    in_y         <= e.y;
    in_wake      <= e.wake;
    script_typed <= typed;
    script_res   <= res;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    events_sent++;
    if (gap_max == 0) begin
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(0, burst_max);
    end
  endtask

  // Stop offering events and wait until every result is back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_written++;
  endtask

  // Result side stall patterns.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 3'd1;
    case (stall_style)
      StallNone:   out_stall <= 1'b0;
      StallRandom: out_stall <= ($urandom_range(0, 3) == 0);
      StallBursts: begin
        if (stall_run != 0) begin
          stall_run <= stall_run - 1;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_run <= $urandom_range(1, 7);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
      default: out_stall <= (stall_tick >= 3'd5);
    endcase
  end

  // Transfer monitor: checks results, predicts accepted events, tracks writes, and
  // ends the run when nothing moves for too long.
  power_result_t exp_res;
  power_result_t new_res;
  logic          moved;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_states.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, state %0d set %0d cause %0d", $time,
                   out_state, out_set, out_cause);
        end else begin
          exp_res = expected_states.pop_front();
          if (out_state !== exp_res.state) begin
            mismatches++;
            $display("%0t: power_state expected %0d, actual %0d", $time, exp_res.state, out_state);
          end
          if (out_set !== exp_res.set) begin
            mismatches++;
            $display("%0t: state_set expected %0d, actual %0d", $time, exp_res.set, out_set);
          end
          if (out_cause !== exp_res.cause) begin
            mismatches++;
            $display("%0t: cause expected %0d, actual %0d", $time, exp_res.cause, out_cause);
          end
          if (out_set === 1'b1) commands_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        moved   = 1'b1;
        new_res = predict_power(mk_ev(in_op, in_now, int'(in_x), int'(in_y), in_wake));
        if (script_typed) new_res = script_res;
        expected_states.push_back(new_res);
        events_taken++;
      end
      if (cfg_we) begin
        moved = 1'b1;
        model_config(cfg_idx, cfg_data);
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, expected_states.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned n;
    int unsigned m;
    int unsigned span;
    int unsigned r1;
    int unsigned r2;
    int          px;
    int          py;
    logic [31:0] first;
    logic        aod;
    logic        idle_en;
    logic [15:0] timeout;
    logic [15:0] palm;
    logic [9:0]  slop;
    logic [15:0] dtap;

    model_reset();

    // Directed script, starting from the reset settings.
    add_chk(OpTick, 32'd0, 0, 0, 16'd0, StOn, 1'b0, CauseNone);
    add_chk(OpPress, 32'd100, -1024, 1023, 16'd0, StOn, 1'b0, CauseNone);
    add_chk(OpHold, 32'd2599, -1024, 1023, 16'd0, StOn, 1'b0, CauseNone);
    add_chk(OpHold, 32'd2600, -1009, 1008, 16'd0, StSleep, 1'b1, CausePalm);
    add_ev(OpRelease, 32'd2700, 0, 0, 16'd0);
    add_ev(OpPress, 32'd3000, 1023, -1024, 16'd0);
    add_chk(OpPress, 32'd3399, 0, 0, 16'd0, StOn, 1'b1, CauseDtap);
    add_chk(OpSleepReq, 32'd4000, 0, 0, 16'd0, StSleep, 1'b1, CauseReq);
    add_ev(OpPress, 32'd5000, 7, 7, 16'd0);
    // A second press exactly at the window edge only re-arms.
    add_chk(OpPress, 32'd5400, 7, 7, 16'd0, StSleep, 1'b0, CauseNone);
    // The tap stays armed across a wake by request.
    add_chk(OpWakeReq, 32'd5450, 0, 0, 16'd0, StOn, 1'b1, CauseReq);
    add_ev(OpSleepReq, 32'd5500, 0, 0, 16'd0);
    add_ev(OpPress, 32'd5700, 3, 3, 16'd0);
    add_chk(OpDeepReq, 32'd7000, 0, 0, 16'd0, StDeep, 1'b1, CauseReq);
    add_chk(OpPress, 32'd7001, 5, 5, 16'd0, StOn, 1'b1, CauseTouch);
    add_chk(OpDeepReq, 32'd8000, 0, 0, 16'hFFFF, StDeep, 1'b1, CauseReq);
    add_chk(OpTick, 32'd65542999, 0, 0, 16'd0, StDeep, 1'b0, CauseNone);
    add_chk(OpTick, 32'd65543000, 0, 0, 16'd0, StOn, 1'b1, CauseAuto);
    // Palm hold across the timestamp wrap, first moved too far, then within the slop.
    add_ev(OpPress, 32'hFFFF_FF00, 100, -100, 16'd0);
    add_ev(OpHold, 32'h0000_0A00, 116, -100, 16'd0);
    add_ev(OpHold, 32'h0000_0A10, 85, -115, 16'd0);
    add_chk(OpUnused, 32'h0000_1234, 0, 0, 16'hFFFF, StSleep, 1'b0, CauseNone);
    // An armed auto-wake survives a wake request and still fires.
    add_ev(OpDeepReq, 32'h0000_2000, 0, 0, 16'd1);
    add_ev(OpWakeReq, 32'h0000_2100, 0, 0, 16'd0);
    add_ev(OpTick, 32'h0000_23E8, 0, 0, 16'd0);
    // Zero inactivity timeout with always-on display selected.
    add_cfg(CfgIdleEnable, 16'd1);
    add_cfg(CfgIdleTimeout, 16'd0);
    add_cfg(CfgAodEnable, 16'd1);
    add_cfg(CfgUnused, 16'hFFFF);
    add_chk(OpTick, 32'h0000_5000, 0, 0, 16'd0, StAod, 1'b1, CauseIdle);
    add_chk(OpTick, 32'h0000_5001, 0, 0, 16'd0, StAod, 1'b0, CauseNone);
    add_ev(OpPress, 32'h0000_5100, 0, 0, 16'd0);
    add_ev(OpPress, 32'h0000_5101, 0, 0, 16'd0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_style = StallRandom;
    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].ev.op, script[i].ev.now[15:0]);
      else send_event(script[i].ev, script[i].typed, script[i].res);
    end
    clock_ms = 32'h0001_0000;

    for (phase = 0; phase < RandomPhases; phase++) begin
      // Settings for this phase: the low extremes, the high extremes, then typical values.
      case (phase)
        0: begin
          aod = 1'b0; idle_en = 1'b1; timeout = 16'd0;
          palm = 16'd0; slop = 10'd0; dtap = 16'd0;
        end
        1: begin
          aod = 1'b1; idle_en = 1'b1; timeout = 16'hFFFF;
          palm = 16'hFFFF; slop = 10'h3FF; dtap = 16'hFFFF;
        end
        default: begin
          aod     = 1'($urandom_range(0, 1));
          idle_en = 1'($urandom_range(0, 1));
          timeout = ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(1, 4));
          palm    = 16'($urandom_range(100, 3000));
          slop    = 10'($urandom_range(0, 40));
          dtap    = 16'($urandom_range(100, 1000));
        end
      endcase
      write_reg(CfgAodEnable, {15'($urandom), aod});
      write_reg(CfgIdleEnable, {15'($urandom), idle_en});
      write_reg(CfgIdleTimeout, timeout);
      write_reg(CfgPalmHold, palm);
      write_reg(CfgPalmSlop, {6'($urandom), slop});
      write_reg(CfgDoubleTap, dtap);
      if (phase == 2) write_reg(CfgUnused, 16'($urandom));

      stall_style = stall_style_e'(phase % 4);
      gap_max     = (phase == 4) ? 0 : $urandom_range(1, 12);
      burst_max   = $urandom_range(0, 20);
      burst_left  = 0;

      phase_end = events_sent + PhaseItems;
      while (events_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) clock_ms += $urandom;
        if (kind < 35) begin
          // Touch gesture: press, a few hold samples near the press point, usually a release.
          clock_ms += $urandom_range(0, 3000);
          px   = int'($urandom_range(0, 2047)) - 1024;
          py   = int'($urandom_range(0, 2047)) - 1024;
          m    = (m_slop > 10'd28) ? 30 : int'(m_slop) + 2;
          span = (m_palm > 16'd4000) ? 4000 : int'(m_palm) + 50;
          scenario_q.push_back(mk_ev(OpPress, clock_ms, px, py, 16'($urandom)));
          n = $urandom_range(1, 4);
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) clock_ms += $urandom_range(0, 70000);
            else clock_ms += $urandom_range(0, span);
            scenario_q.push_back(mk_ev(OpHold, clock_ms,
                                       px + int'($urandom_range(0, 2 * m)) - int'(m),
                                       py + int'($urandom_range(0, 2 * m)) - int'(m),
                                       16'($urandom)));
          end
          if ($urandom_range(0, 3) != 0) begin
            clock_ms += $urandom_range(0, 500);
            scenario_q.push_back(mk_ev(OpRelease, clock_ms, $urandom, $urandom, 16'($urandom)));
          end
        end else if (kind < 55) begin
          // Double tap with the second press on either side of the window.
          clock_ms += $urandom_range(0, 3000);
          span  = (m_dtap > 16'd1500) ? 1500 : int'(m_dtap);
          r2    = $urandom_range(0, 2 * span + 1);
          r1    = $urandom_range(0, r2);
          first = clock_ms;
          scenario_q.push_back(mk_ev(OpPress, first, $urandom, $urandom, 16'($urandom)));
          scenario_q.push_back(mk_ev(OpRelease, first + r1, $urandom, $urandom, 16'($urandom)));
          scenario_q.push_back(mk_ev(OpPress, first + r2, $urandom, $urandom, 16'($urandom)));
          clock_ms = first + r2 + $urandom_range(0, 200);
          scenario_q.push_back(mk_ev(OpRelease, clock_ms, $urandom, $urandom, 16'($urandom)));
        end else if (kind < 70) begin
          // Ticks, now and then after a long silence.
          n = $urandom_range(1, 3);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0) clock_ms += $urandom_range(0, 70000000);
            else clock_ms += $urandom_range(0, 6000);
            scenario_q.push_back(mk_ev(OpTick, clock_ms, $urandom, $urandom, 16'($urandom)));
          end
        end else if (kind < 84) begin
          // Explicit requests, deep sleep often with a short auto-wake.
          clock_ms += $urandom_range(0, 2000);
          case ($urandom_range(0, 3))
            0:       r1 = 0;
            3:       r1 = $urandom_range(0, 65535);
            default: r1 = $urandom_range(1, 3);
          endcase
          case ($urandom_range(0, 2))
            0:       scenario_q.push_back(mk_ev(OpSleepReq, clock_ms, $urandom, $urandom, 16'(r1)));
            1:       scenario_q.push_back(mk_ev(OpDeepReq, clock_ms, $urandom, $urandom, 16'(r1)));
            default: scenario_q.push_back(mk_ev(OpWakeReq, clock_ms, $urandom, $urandom, 16'(r1)));
          endcase
        end else begin
          // Noise: any op with any timestamp.
          n = $urandom_range(1, 3);
          repeat (n) begin
            scenario_q.push_back(mk_ev(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                       16'($urandom)));
          end
        end
        while (scenario_q.size() != 0) send_event(scenario_q.pop_front(), 1'b0, '0);
      end
    end

    drain();
    $display("Ran %0d events through %0d register writes in %0d random phases plus a script.",
             events_taken, settings_written, RandomPhases);
    $display("%0d results commanded a state; %0d mismatches.", commands_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
